// File: rtl/tci_pkg.sv
// Shared types, codes, constants and the arctangent table of the turtle command interpreter.
package tci_pkg;

    localparam int XW = 36;   // CORDIC x/y datapath width
    localparam int ZW = 26;   // CORDIC angle width, 1/65536 degree
    localparam int ATAN_COUNT = 24;

    localparam logic [2:0] CMD_LONG   = 3'd0;
    localparam logic [2:0] CMD_SHORT  = 3'd1;
    localparam logic [2:0] CMD_RIGHT  = 3'd2;
    localparam logic [2:0] CMD_LEFT   = 3'd3;
    localparam logic [2:0] CMD_PUSH   = 3'd4;
    localparam logic [2:0] CMD_POP    = 3'd5;
    localparam logic [2:0] CMD_MOVE   = 3'd6;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_MOVE = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OVF  = 2'd1;
    localparam logic [1:0] STAT_UNF  = 2'd2;
    localparam logic [1:0] STAT_SAT  = 2'd3;

    localparam logic [1:0] REG_LONG  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_TURN  = 2'd2;

    localparam logic [16:0] FULL_TURN    = 17'd92160;
    localparam logic [16:0] QUARTER_TURN = 17'd23040;
    localparam logic [16:0] HALF_TURN    = 17'd46080;
    localparam logic [16:0] THREEQ_TURN  = 17'd69120;
    localparam logic [29:0] GAIN_Q30     = 30'd652032874;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [16:0]        heading;
        logic [1:0]         segment_kind;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic iter;
        logic round;
        logic step_commit;
        logic pop_commit;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_ok;
        logic iter_last;
    } t_dp_status;

    function automatic logic [21:0] atan_deg16(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // {saturated, value}
    function automatic logic [32:0] sat_to32(input logic signed [XW-1:0] v);
        logic [32:0] r;
        if (v > $signed({{(XW-31){1'b0}}, 31'h7FFFFFFF})) begin
            r = {1'b1, 32'h7FFFFFFF};
        end else if (v < $signed({{(XW-31){1'b1}}, 31'h0})) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/tci_ram.sv
// Generic single-port RAM with registered read.
module tci_ram #(
    parameter int WIDTH = 81,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tci_ctrl.sv
// Sequencing state machine of the turtle command interpreter.
module tci_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [2:0]          i_cmd,
    input  tci_pkg::t_dp_status i_status,
    input  logic                i_out_free,
    output logic                o_in_stall,
    output tci_pkg::t_dp_cmd    o_dp_cmd,
    output logic                o_out_load
);
    import tci_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROT  = 6'b000010,
        S_RND  = 6'b000100,
        S_SAT  = 6'b001000,
        S_POP  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_dp_cmd    = '0;
        o_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_dp_cmd.start = 1'b1;
                    if (i_cmd inside {CMD_LONG, CMD_SHORT}) begin
                        n_state = S_ROT;
                    end else if (i_cmd == CMD_POP && i_status.pop_ok) begin
                        n_state = S_POP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ROT: begin
                o_dp_cmd.iter = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_dp_cmd.round = 1'b1;
                n_state = S_SAT;
            end
            S_SAT: begin
                o_dp_cmd.step_commit = 1'b1;
                n_state = S_DONE;
            end
            S_POP: begin
                o_dp_cmd.pop_commit = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule

// File: rtl/tci_dp.sv
// Datapath: turtle state, CORDIC step unit, heading update and state stack.
module tci_dp #(
    parameter int STACK_DEPTH  = 64,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tci_pkg::t_dp_cmd    i_cmd,
    input  tci_pkg::t_in_item   i_item,
    input  logic [23:0]         i_long_len,
    input  logic [23:0]         i_short_len,
    input  logic [16:0]         i_turn_step,
    output tci_pkg::t_dp_status o_status,
    output tci_pkg::t_out_item  o_result
);
    import tci_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int ITER_N = (CORDIC_ITERS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_ITERS;
    localparam int SW = 32 + 32 + 17;

    logic signed [31:0] r_x, r_y;
    logic [16:0]        r_heading;
    logic [LW-1:0]      r_level;
    logic [1:0]         r_kind, r_status;

    logic signed [XW-1:0] r_cx, r_cy, r_dx, r_dy;
    logic signed [ZW-1:0] r_z;
    logic [1:0]           r_q;
    logic [4:0]           r_iter;

    // step setup
    logic [23:0]          len_sel;
    logic [53:0]          prod;
    logic [1:0]           q0;
    logic [16:0]          rem;
    always_comb begin
        len_sel = (i_item.cmd == CMD_LONG) ? i_long_len : i_short_len;
        prod    = {30'd0, len_sel} * {24'd0, GAIN_Q30};
        if (r_heading >= FULL_TURN) begin
            q0 = 2'd0; rem = r_heading - FULL_TURN;
        end else if (r_heading >= THREEQ_TURN) begin
            q0 = 2'd3; rem = r_heading - THREEQ_TURN;
        end else if (r_heading >= HALF_TURN) begin
            q0 = 2'd2; rem = r_heading - HALF_TURN;
        end else if (r_heading >= QUARTER_TURN) begin
            q0 = 2'd1; rem = r_heading - QUARTER_TURN;
        end else begin
            q0 = 2'd0; rem = r_heading;
        end
    end

    // heading turn with wrap into 0..FULL_TURN
    logic signed [18:0] a0, a1, a2;
    localparam logic signed [18:0] FT19 = 19'sd92160;
    always_comb begin
        if (i_item.cmd == CMD_RIGHT) begin
            a0 = $signed({2'b00, r_heading}) + $signed({2'b00, i_turn_step});
        end else begin
            a0 = $signed({2'b00, r_heading}) - $signed({2'b00, i_turn_step});
        end
        a1 = (a0 > FT19) ? a0 - FT19 : ((a0 < 0) ? a0 + FT19 : a0);
        a2 = (a1 > FT19) ? a1 - FT19 : ((a1 < 0) ? a1 + FT19 : a1);
    end

    // CORDIC iteration
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = r_cx >>> r_iter;
    assign ys = r_cy >>> r_iter;
    assign at = $signed({{(ZW-22){1'b0}}, atan_deg16(r_iter)});

    // quadrant map
    logic signed [XW-1:0] sn, cs;
    always_comb begin
        case (r_q)
            2'd0:    begin sn = r_cy;  cs = r_cx;  end
            2'd1:    begin sn = r_cx;  cs = -r_cy; end
            2'd2:    begin sn = -r_cy; cs = -r_cx; end
            default: begin sn = -r_cx; cs = r_cy;  end
        endcase
    end

    logic [32:0] sat_x, sat_y;
    assign sat_x = sat_to32($signed({{(XW-32){r_x[31]}}, r_x}) + r_dx);
    assign sat_y = sat_to32($signed({{(XW-32){r_y[31]}}, r_y}) + r_dy);

    // stack RAM
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [LW-1:0]  level_dec;
    logic [SW-1:0]  ram_rdata;
    logic           full;
    assign full      = (r_level >= LW'(STACK_DEPTH));
    assign level_dec = r_level - LW'(1);
    assign ram_we    = i_cmd.start && (i_item.cmd == CMD_PUSH) && !full;
    assign ram_addr  = (i_item.cmd == CMD_PUSH) ? r_level[AW-1:0] : level_dec[AW-1:0];

    tci_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({r_x, r_y, r_heading}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_heading <= '0;
            r_level   <= '0;
            r_iter    <= '0;
        end else begin
            if (i_cmd.start) begin
                case (i_item.cmd)
                    CMD_LONG, CMD_SHORT: begin
                        r_kind   <= KIND_LINE;
                        r_status <= STAT_OK;
                        r_cx     <= $signed({{(XW-32){1'b0}}, prod[53:22]});
                        r_cy     <= '0;
                        r_z      <= $signed({{(ZW-23){1'b0}}, rem[14:0], 8'd0});
                        r_q      <= q0;
                        r_iter   <= '0;
                    end
                    CMD_RIGHT, CMD_LEFT: begin
                        r_kind    <= KIND_NONE;
                        r_status  <= STAT_OK;
                        r_heading <= a2[16:0];
                    end
                    CMD_PUSH: begin
                        r_kind <= KIND_NONE;
                        if (full) begin
                            r_status <= STAT_OVF;
                        end else begin
                            r_status <= STAT_OK;
                            r_level  <= r_level + LW'(1);
                        end
                    end
                    CMD_POP: begin
                        if (r_level == '0) begin
                            r_kind   <= KIND_NONE;
                            r_status <= STAT_UNF;
                        end else begin
                            r_level  <= level_dec;
                            r_kind   <= KIND_MOVE;
                            r_status <= STAT_OK;
                        end
                    end
                    CMD_MOVE: begin
                        r_x      <= i_item.target_x;
                        r_y      <= i_item.target_y;
                        r_kind   <= KIND_MOVE;
                        r_status <= STAT_OK;
                    end
                    default: begin
                        r_kind   <= KIND_NONE;
                        r_status <= STAT_OK;
                    end
                endcase
            end
            if (i_cmd.iter) begin
                if (!r_z[ZW-1]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_z  <= r_z - at;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_z  <= r_z + at;
                end
                if (!o_status.iter_last) begin
                    r_iter <= r_iter + 5'd1;
                end
            end
            if (i_cmd.round) begin
                r_dx <= (sn + XW'(128)) >>> 8;
                r_dy <= (cs + XW'(128)) >>> 8;
            end
            if (i_cmd.step_commit) begin
                r_x      <= sat_x[31:0];
                r_y      <= sat_y[31:0];
                r_status <= (sat_x[32] || sat_y[32]) ? STAT_SAT : STAT_OK;
            end
            if (i_cmd.pop_commit) begin
                r_x       <= ram_rdata[SW-1 -: 32];
                r_y       <= ram_rdata[48:17];
                r_heading <= ram_rdata[16:0];
            end
        end
    end

    assign o_status.pop_ok    = (r_level != '0);
    assign o_status.iter_last = (r_iter == 5'(ITER_N - 1));

    assign o_result.pos_x        = r_x;
    assign o_result.pos_y        = r_y;
    assign o_result.heading      = r_heading;
    assign o_result.segment_kind = r_kind;
    assign o_result.status       = r_status;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading <= FULL_TURN)
        else $error("heading out of range");
    a_round_after_iters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> (r_iter == 5'(ITER_N - 1)) && $past(i_cmd.iter))
        else $error("rounding before all CORDIC iterations");
endmodule

// File: rtl/turtle_command_interpreter_unit.sv
// Top level of the turtle command interpreter: APB registers, output register, ctrl and datapath.
//
//  channel   dir   handshake               payload
//  input     in    i_in_valid / o_in_stall  i_in  (cmd, target_x, target_y)
//  output    out   o_out_valid / i_out_stall o_out (pos_x, pos_y, heading, segment_kind, status)
//  config    in    APB psel/penable/pwrite  paddr, pwdata, prdata
//
// One request in flight at a time. A step runs the CORDIC iterations in S_ROT, then rounds
// in S_RND and saturates and commits in S_SAT before its result waits in S_DONE; the shared
// CORDIC unit does one iteration per cycle. Turns, push and move go straight to S_DONE;
// a successful pop passes through S_POP (one stack RAM read).
// Reset is synchronous; the stack RAM is not cleared, entries are read only once pushed.
// A finished result waits in the output register; a new request is taken meanwhile.
module turtle_command_interpreter_unit #(
    parameter int STACK_DEPTH  = 64,
    parameter int CORDIC_ITERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tci_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tci_pkg::t_out_item o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tci_pkg::*;

    // configuration registers
    logic [23:0] r_long_len, r_short_len;
    logic [16:0] r_turn_step;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_len  <= 24'd65536;
            r_short_len <= 24'd32768;
            r_turn_step <= 17'd11520;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LONG:  r_long_len  <= pwdata[23:0];
                REG_SHORT: r_short_len <= pwdata[23:0];
                REG_TURN:  r_turn_step <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LONG:  prdata = {8'd0, r_long_len};
            REG_SHORT: prdata = {8'd0, r_short_len};
            REG_TURN:  prdata = {15'd0, r_turn_step};
            default:   prdata = '0;
        endcase
    end

    // controller <-> datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_out_item  dp_result;
    logic       out_load, out_free;

    // output register frees when empty or being taken this cycle
    logic      r_out_valid;
    t_out_item r_out;
    assign out_free = !r_out_valid || !i_out_stall;

    tci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in.cmd),
        .i_status   (dp_status),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_dp_cmd   (dp_cmd),
        .o_out_load (out_load)
    );

    tci_dp #(
        .STACK_DEPTH  (STACK_DEPTH),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_item      (i_in),
        .i_long_len  (r_long_len),
        .i_short_len (r_short_len),
        .i_turn_step (r_turn_step),
        .o_status    (dp_status),
        .o_result    (dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
